// ----- rtl/core/wmb_pkg.sv -----
`default_nettype none
package wmb_pkg;

    localparam int RING_DEPTH = 512;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = $clog2(RING_DEPTH);

    localparam logic [15:0] HEIGHT_MAX = 16'd64000;

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_CAPTURED = 2'd2;
    localparam logic [1:0] ST_TOO_FEW  = 2'd3;

    localparam logic FUNC_PUSH    = 1'b0;
    localparam logic FUNC_CAPTURE = 1'b1;

    localparam logic REG_MIN_SAMPLES = 1'b0;
    localparam logic REG_STORED_BASE = 1'b1;

    typedef struct packed {
        logic push;
        logic load;
        logic count;
        logic find;
    } wmb_ctrl_t;

    typedef struct packed {
        logic [15:0] cir;
        logic        cirv;
        logic [15:0] fd;
        logic        fv;
    } wmb_link_t;

endpackage
`default_nettype wire

// ----- rtl/core/wmb_cell.sv -----
`default_nettype none
module wmb_cell (
    input  wire                  clk,
    input  wire wmb_pkg::wmb_ctrl_t ctrl,
    input  wire                  valid,
    input  wire [wmb_pkg::CW-1:0] rank,
    input  wire [15:0]           v_in,
    output logic [15:0]          v_out,
    input  wire wmb_pkg::wmb_link_t link_in,
    output wmb_pkg::wmb_link_t   link_out
);

    logic [15:0]          v_reg;
    logic [15:0]          cir_reg;
    logic                 cirv_reg;
    logic [15:0]          fd_reg;
    logic                 fv_reg;
    logic [wmb_pkg::CW-1:0] below_reg;
    logic [wmb_pkg::CW-1:0] upto_reg;
    logic                 match;

    assign match = valid && (below_reg <= rank) && (rank < upto_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            v_reg <= v_in;
        end
        if (ctrl.load)
        begin
            cir_reg   <= v_reg;
            cirv_reg  <= valid;
            below_reg <= '0;
            upto_reg  <= '0;
            fv_reg    <= 1'b0;
            fd_reg    <= '0;
        end
        else if (ctrl.count)
        begin
            cir_reg  <= link_in.cir;
            cirv_reg <= link_in.cirv;
            if (cirv_reg && valid)
            begin
                if (cir_reg < v_reg)
                begin
                    below_reg <= below_reg + 1'b1;
                end
                if (cir_reg <= v_reg)
                begin
                    upto_reg <= upto_reg + 1'b1;
                end
            end
        end
        else if (ctrl.find)
        begin
            fv_reg <= link_in.fv | match;
            fd_reg <= link_in.fv ? link_in.fd : v_reg;
        end
    end

    assign v_out         = v_reg;
    assign link_out.cir  = cir_reg;
    assign link_out.cirv = cirv_reg;
    assign link_out.fd   = fd_reg;
    assign link_out.fv   = fv_reg;

endmodule
`default_nettype wire

// ----- rtl/core/window_median_baseline.sv -----
`default_nettype none
// Median baseline learner. A push beat's result is ready the next cycle; a capture
// beat that has enough samples steps through the load, count, find and done states,
// driving a row of cells that rotates all held samples past each other for ranking
// and then walks the selected value down the row. Samples are held in the cells as a
// shift line, newest at the head. Results are held in an output register, and a new
// beat is taken while the last result is being taken.
module window_median_baseline (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] height
    input  wire         s_tuser,   // [0] func
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [1:0] status, [11:2] filled_count, [27:12] baseline
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int D  = wmb_pkg::RING_DEPTH;
    localparam int CW = wmb_pkg::CW;
    localparam int PW = wmb_pkg::PW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [PW-1:0] LAST = PW'(D - 1);

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0]   learned_reg, learned_next;
    logic [9:0]    min_reg;
    logic [15:0]   stored_reg;
    logic          ov_reg, ov_next;
    logic [1:0]    ost_reg, ost_next;
    logic [9:0]    ofill_reg, ofill_next;
    logic [15:0]   obase_reg, obase_next;

    wmb_pkg::wmb_ctrl_t ctrl;
    wmb_pkg::wmb_link_t link_in  [D];
    wmb_pkg::wmb_link_t link_out [D];
    logic [15:0]        v_in     [D];
    logic [15:0]        v_out    [D];
    logic [D-1:0]       cvalid;

    logic accept, hok, enough, cfg_wr;
    logic [CW-1:0] rank;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[2] == wmb_pkg::REG_STORED_BASE) ? {16'd0, stored_reg}
                                                              : {22'd0, min_reg};
    assign s_tready = (state_reg == S_IDLE) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign hok      = (s_tdata != 16'd0) && (s_tdata <= wmb_pkg::HEIGHT_MAX);
    assign enough   = (fill_reg != '0) && (16'(min_reg) <= 16'(fill_reg));
    assign rank     = fill_reg >> 1;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, obase_reg, ofill_reg, ost_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= 10'd16;
            stored_reg <= 16'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == wmb_pkg::REG_MIN_SAMPLES)
            begin
                min_reg <= pwdata[9:0];
            end
            else
            begin
                stored_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        fill_next    = fill_reg;
        learned_next = learned_reg;
        ov_next      = ov_reg && !m_tready;
        ost_next     = ost_reg;
        ofill_next   = ofill_reg;
        obase_next   = obase_reg;
        ctrl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ov_next    = 1'b1;
                    ofill_next = fill_reg[9:0];
                    obase_next = (learned_reg != 16'd0) ? learned_reg : stored_reg;
                    if (s_tuser == wmb_pkg::FUNC_PUSH)
                    begin
                        if (hok)
                        begin
                            ctrl.push = 1'b1;
                            if (fill_reg != CW'(D))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            ofill_next = fill_next[9:0];
                            ost_next   = wmb_pkg::ST_STORED;
                        end
                        else
                        begin
                            ost_next = wmb_pkg::ST_REJECTED;
                        end
                    end
                    else if (enough)
                    begin
                        ov_next    = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        ost_next = wmb_pkg::ST_TOO_FEW;
                    end
                end
            end
            S_LOAD:
            begin
                ctrl.load  = 1'b1;
                cnt_next   = '0;
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                ctrl.count = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                ctrl.find = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                learned_next = link_out[D-1].fd;
                ov_next      = 1'b1;
                ost_next     = wmb_pkg::ST_CAPTURED;
                ofill_next   = fill_reg[9:0];
                obase_next   = (link_out[D-1].fd != 16'd0) ? link_out[D-1].fd : stored_reg;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            fill_reg    <= '0;
            learned_reg <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            fill_reg    <= fill_next;
            learned_reg <= learned_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ost_reg   <= ost_next;
        ofill_reg <= ofill_next;
        obase_reg <= obase_next;
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            cvalid[i] = (fill_reg > CW'(i));
            if (i == 0)
            begin
                v_in[i]         = s_tdata;
                link_in[i].cir  = link_out[D-1].cir;
                link_in[i].cirv = link_out[D-1].cirv;
                link_in[i].fd   = '0;
                link_in[i].fv   = 1'b0;
            end
            else
            begin
                v_in[i]    = v_out[i-1];
                link_in[i] = link_out[i-1];
            end
        end
    end

    for (genvar g = 0; g < D; g++)
    begin : g_cell
        wmb_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .valid    (cvalid[g]),
            .rank     (rank),
            .v_in     (v_in[g]),
            .v_out    (v_out[g]),
            .link_in  (link_in[g]),
            .link_out (link_out[g])
        );
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("beat taken during capture");

    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> link_out[D-1].fv)
        else $error("no median found at end of capture");

    a_captured_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ost_reg == wmb_pkg::ST_CAPTURED) |-> (learned_reg != 16'd0))
        else $error("captured baseline is zero");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(D))
        else $error("fill count beyond depth");

endmodule
`default_nettype wire
